/* design/lsq_pkg.sv */
// Types, item codes, sequencer states and the tanh ROM for the learnable scalar quantizer.
package lsq_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SET   = 2'd1,
        KIND_QUANT = 2'd2,
        KIND_DEQ   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [4:0]         dim;
        logic [3:0]         level;
        logic [15:0]        center_value;
        logic [4:0]         level_count;
        logic signed [15:0] sample;
    } lsq_in_t;

    typedef struct packed {
        logic [3:0]         level_index;
        logic signed [15:0] quantized;
        logic               status;
    } lsq_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ROM,
        S_INTERP,
        S_APPROX,
        S_WALK,
        S_DRAIN,
        S_DEQ,
        S_DONE
    } state_t;

    // Upper half of the table: round(65535 * (1 + tanh(j/16)) / 2), j = 0..128.
    // The lower half follows from symmetry: T[128-j] = 65535 - T[128+j].
    localparam int TANH_HALF_N = 129;

    typedef logic [15:0] tanh_half_t [0:TANH_HALF_N-1];

    function automatic tanh_half_t build_tanh_half();
        tanh_half_t r;
        real        v;
        for (int j = 0; j < TANH_HALF_N; j++) begin
            v    = 65535.0 * (1.0 + $tanh(j / 16.0)) / 2.0;
            r[j] = 16'($rtoi($floor(v + 0.5)));
        end
        return r;
    endfunction

    localparam tanh_half_t TANH_HALF = build_tanh_half();

    // Full 257-point table, k = 0..256
    function automatic logic [15:0] tanh_lookup(input logic [8:0] k);
        logic [7:0]  j;
        logic [15:0] v;
        if (k >= 9'd128) begin
            j = 8'(k - 9'd128);
        end
        else begin
            j = 8'(9'd128 - k);
        end
        v = TANH_HALF[j];
        return (k >= 9'd128) ? v : (16'hFFFF - v);
    endfunction

endpackage

/* design/learnable_scalar_quantizer.sv */
// Per-dimension learnable scalar quantizer: center store, tanh map and nearest-center search.
//
//   channel   | valid        | stall         | payload
//   ----------+--------------+---------------+--------------------------
//   item      | item_valid   | item_stall    | item   (lsq_pkg::lsq_in_t)
//   result    | result_valid | result_stall  | result (lsq_pkg::lsq_out_t)
//
// Write and set go from decode straight to the output load; dequantize passes the S_DEQ center
// read on the way. Quantize runs decode, second ROM read, interpolation (S_INTERP, S_APPROX), one
// center per cycle through the shared subtract/compare unit, a drain state and the output load.
// Errors go from decode to the output load, or via the ROM state for a zero-count quantize.
// item_stall is high until the result is in the output register, so the next item goes in
// on the following cycle; a stalled result holds there while that item runs. Reset clears the
// level count valid bits and the sequencer; centers are undefined.
module learnable_scalar_quantizer #(
    parameter int MAX_DIMS   = 32,
    parameter int MAX_LEVELS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lsq_pkg::lsq_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output lsq_pkg::lsq_out_t result
);
    import lsq_pkg::*;

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int LVL_W = $clog2(MAX_LEVELS);
    localparam int CA_W  = $clog2(MAX_DIMS * MAX_LEVELS);

    state_t            state_reg, state_next;
    lsq_in_t           item_reg;
    logic              err_reg, err_next;
    logic [4:0]        cnt_mem [0:MAX_DIMS-1];
    logic [4:0]        cnt_rd_reg;
    logic              cnt_vld_rd_reg;
    logic [MAX_DIMS-1:0] cnt_valid_reg;
    logic [15:0]       center_mem [0:MAX_DIMS*MAX_LEVELS-1];
    logic [15:0]       cdata_reg;
    logic [15:0]       rom_q_reg;
    logic [15:0]       t0_reg, t0_next;
    logic [23:0]       prod_reg, prod_next;
    logic [15:0]       a_reg, a_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [LVL_W-1:0]  cmp_lvl_reg;
    logic [16:0]       bd_reg, bd_next;
    logic [LVL_W-1:0]  best_reg, best_next;
    logic [15:0]       bestc_reg, bestc_next;
    logic              out_valid_reg, out_valid_next;
    lsq_out_t          out_reg, out_next;

    logic              item_accept;
    logic              out_load;
    logic              c_we;
    logic              cnt_we;
    logic [DIM_W-1:0]  dim_idx;
    logic [LVL_W-1:0]  c_lvl;
    logic [CA_W-1:0]   c_addr;
    logic [8:0]        rom_k;
    logic [15:0]       u;
    logic [4:0]        cnt_eff;
    logic              walk_last;
    logic              dim_ok, lvl_ok, cnt_ok;
    logic [15:0]       c_diff;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign dim_idx = DIM_W'(item_reg.dim);
    assign c_lvl   = (state_reg == S_WALK) ? lvl_reg : LVL_W'(item_reg.level);
    assign c_addr  = CA_W'(int'(dim_idx) * MAX_LEVELS + int'(c_lvl));
    assign u       = item_reg.sample ^ 16'h8000;
    assign rom_k   = (state_reg == S_ROM) ? ({1'b0, u[15:8]} + 9'd1) : {1'b0, u[15:8]};
    assign cnt_eff = cnt_vld_rd_reg ? cnt_rd_reg : 5'd0;

    assign dim_ok = (32'(item_reg.dim) < MAX_DIMS);
    assign lvl_ok = (32'(item_reg.level) < MAX_LEVELS);
    assign cnt_ok = (32'(item_reg.level_count) <= MAX_LEVELS);

    assign walk_last = (({1'b0, lvl_reg} + (LVL_W+1)'(1)) == (LVL_W+1)'(cnt_eff));
    assign c_diff    = (a_reg > cdata_reg) ? (a_reg - cdata_reg) : (cdata_reg - a_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!dim_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (item_reg.kind)
                        KIND_QUANT: state_next = S_ROM;
                        KIND_DEQ:   state_next = lvl_ok ? S_DEQ : S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ROM:    state_next = (cnt_eff == 5'd0) ? S_DONE : S_INTERP;
            S_INTERP: state_next = S_APPROX;
            S_APPROX: state_next = S_WALK;
            S_WALK:   state_next = walk_last ? S_DRAIN : S_WALK;
            S_DRAIN:  state_next = S_DONE;
            S_DEQ:    state_next = S_DONE;
            S_DONE:   state_next = out_load ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        err_next       = err_reg;
        t0_next        = t0_reg;
        prod_next      = prod_reg;
        a_next         = a_reg;
        lvl_next       = lvl_reg;
        cmp_vld_next   = (state_reg == S_WALK);
        bd_next        = bd_reg;
        best_next      = best_reg;
        bestc_next     = bestc_reg;
        c_we           = 1'b0;
        cnt_we         = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        case (state_reg)
            S_DECODE:
            begin
                bd_next  = '1;
                lvl_next = '0;
                err_next = !dim_ok;
                case (item_reg.kind)
                    KIND_WRITE:
                    begin
                        err_next = !dim_ok || !lvl_ok;
                        c_we     = dim_ok && lvl_ok;
                    end
                    KIND_SET:
                    begin
                        err_next = !dim_ok || !cnt_ok;
                        cnt_we   = dim_ok && cnt_ok;
                    end
                    KIND_DEQ:   err_next = !dim_ok || !lvl_ok;
                    default:    err_next = !dim_ok;
                endcase
            end
            S_ROM:
            begin
                err_next = (cnt_eff == 5'd0);
                t0_next  = rom_q_reg;
            end
            S_INTERP:
            begin
                // table is monotonic, so T[k+1] - T[k] never wraps
                prod_next = 24'(rom_q_reg - t0_reg) * 24'(u[7:0]) + 24'd128;
            end
            S_APPROX:
            begin
                a_next = t0_reg + prod_reg[23:8];
            end
            S_WALK:
            begin
                lvl_next = lvl_reg + LVL_W'(1);
            end
            S_DEQ:
            begin
                best_next  = LVL_W'(item_reg.level);
                bestc_next = cdata_reg;
            end
            default:
            begin
            end
        endcase

        // shared compare: strictly smaller distance wins, so ties keep the lower level
        if (cmp_vld_reg && ({1'b0, c_diff} < bd_reg))
        begin
            bd_next    = {1'b0, c_diff};
            best_next  = cmp_lvl_reg;
            bestc_next = cdata_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (err_reg || item_reg.kind == KIND_WRITE || item_reg.kind == KIND_SET)
            begin
                out_next.level_index = '0;
                out_next.quantized   = '0;
            end
            else
            begin
                out_next.level_index = 4'(best_reg);
                out_next.quantized   = bestc_reg ^ 16'h8000;
            end
            out_next.status = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_valid_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                cnt_valid_reg[dim_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg <= item;
        end
        err_reg     <= err_next;
        t0_reg      <= t0_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        lvl_reg     <= lvl_next;
        cmp_lvl_reg <= lvl_reg;
        bd_reg      <= bd_next;
        best_reg    <= best_next;
        bestc_reg   <= bestc_next;
        out_reg     <= out_next;
        rom_q_reg   <= tanh_lookup(rom_k);
    end

    // level count store
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[dim_idx] <= item_reg.level_count;
        end
        cnt_rd_reg     <= cnt_mem[dim_idx];
        cnt_vld_rd_reg <= cnt_valid_reg[dim_idx];
    end

    // center store
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            center_mem[c_addr] <= item_reg.center_value;
        end
        cdata_reg <= center_mem[c_addr];
    end

`ifndef SYNTHESIS
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> ({1'b0, lvl_reg} < (LVL_W+1)'(cnt_eff)))
        else $error("center walk past level count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> (result.level_index == '0 && result.quantized == '0))
        else $error("error result carries nonzero payload");

    a_cmp_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("compare outside center walk");
`endif

endmodule
